// ===== hw/rtl/sle_pkg.sv =====
package sle_pkg;

    // Input operations
    typedef enum logic [1:0] {
        OP_RX_BYTE     = 2'd0,
        OP_SET_FACTORY = 2'd1,
        OP_CLEAR_LINE  = 2'd2,
        OP_READ_ENTRY  = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_LINE_DONE = 3'd1,
        KIND_FACTORY   = 3'd2,
        KIND_CAPTURE   = 3'd3,
        KIND_READ      = 3'd4,
        KIND_STATUS    = 3'd5
    } t_kind;

    // Configuration register indexes
    localparam logic CFG_CAPTURE_MODE  = 1'b0;
    localparam logic CFG_LINE_END_CHAR = 1'b1;

    localparam logic [7:0] LINE_END_RESET = 8'h0d;

    // Control characters
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] CH_NL  = 8'h0a;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Most results one item can produce
    localparam int RES_MAX   = 4;
    localparam int RES_IDX_W = 2;

    typedef struct packed {
        t_op        operation;
        logic [7:0] data_byte;
        logic [7:0] entry_index;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] line_length;
        logic       line_done;
        logic       factory_on;
        logic       last;
    } t_out_item;

endpackage

// ===== hw/rtl/serial_line_editor_echo_core.sv =====
// Serial line editor with echo. Each received byte item is edited against a
// LINE_LEN byte line store and answered by one to four result items (echo,
// erase sequence, newline and line-complete). An item is taken and then holds
// the output until each of its results has been taken, so the block sustains
// one item per cycle for single-result items while the output is not stalled;
// the next item is taken in the same cycle the last result of the previous one
// is taken. The line store is a single-port write, single-port read memory; an
// entry read is issued when the item is taken and its data appears with the
// item's result in the next cycle. Clear line and reset take effect at once
// through a fill mark (entries past the highest position written since the
// last clear read as zero), so there is no clearing pass. Configuration
// writes take effect on the next item.
module serial_line_editor_echo_core #(
    parameter int LINE_LEN = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sle_pkg::t_in_item  i_in_item,
    // Result item channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sle_pkg::t_out_item o_out_item,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import sle_pkg::*;

    localparam int AW = $clog2(LINE_LEN);
    localparam int LW = (AW + 1 > 8) ? AW + 1 : 8;

    // Configuration
    logic                 r_capture;
    logic [7:0]           r_line_end;

    // Editor state
    logic [AW-1:0]        r_count, n_count;
    logic [AW:0]          r_fill, n_fill;
    logic                 r_done, n_done;
    logic                 r_factory, n_factory;

    // Line store
    logic [7:0]           r_line_mem [LINE_LEN];
    logic [7:0]           r_rd_data;

    // Result stage
    logic                 r_valid;
    logic [RES_IDX_W-1:0] r_idx;
    logic [RES_IDX_W-1:0] r_last_idx, n_last_idx;
    logic                 r_is_read, n_is_read;
    logic                 r_in_range;
    t_kind                r_kind [RES_MAX];
    t_kind                n_kind [RES_MAX];
    logic [7:0]           r_val [RES_MAX];
    logic [7:0]           n_val [RES_MAX];

    logic                 in_acc;
    logic                 out_acc;
    logic                 out_last;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic [AW:0]          count_inc;
    logic [7:0]           rx_byte;

    // Handshakes
    assign out_last   = (r_idx == r_last_idx);
    assign out_acc    = r_valid && i_out_ready;
    assign o_in_ready = !r_valid || (i_out_ready && out_last);
    assign in_acc     = i_in_valid && o_in_ready;
    assign rx_byte    = i_in_item.data_byte;
    assign count_inc  = {1'b0, r_count} + (AW+1)'(1);

    // Decode the item against the current state
    always_comb begin
        n_count    = r_count;
        n_fill     = r_fill;
        n_done     = r_done;
        n_factory  = r_factory;
        n_last_idx = '0;
        n_is_read  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_count;
        wr_data    = '0;
        for (int k = 0; k < RES_MAX; k++) begin
            n_kind[k] = KIND_ECHO;
            n_val[k]  = '0;
        end
        unique case (i_in_item.operation)
            OP_RX_BYTE: begin
                priority if (r_capture) begin
                    n_kind[0] = KIND_CAPTURE;
                    n_val[0]  = rx_byte;
                end else if (rx_byte == CH_ESC) begin
                    n_factory = 1'b0;
                    n_kind[0] = KIND_STATUS;
                end else if (r_factory) begin
                    n_kind[0] = KIND_FACTORY;
                    n_val[0]  = rx_byte;
                end else if (rx_byte == r_line_end) begin
                    // echo, newline, then line complete
                    n_done     = 1'b1;
                    n_val[0]   = rx_byte;
                    n_val[1]   = CH_NL;
                    n_kind[2]  = KIND_LINE_DONE;
                    n_last_idx = RES_IDX_W'(2);
                end else if (rx_byte != CH_BS && rx_byte != CH_DEL) begin
                    // store and advance, wrapping when the line is full
                    n_val[0] = rx_byte;
                    wr_en    = 1'b1;
                    wr_data  = rx_byte;
                    n_count  = (count_inc == (AW+1)'(LINE_LEN)) ? '0 : count_inc[AW-1:0];
                    if (count_inc > r_fill) begin
                        n_fill = count_inc;
                    end
                end else begin
                    // erase: zero the vacated slot (slot 0 on an empty line)
                    n_val[0] = rx_byte;
                    wr_en    = 1'b1;
                    wr_addr  = '0;
                    if (r_count != '0) begin
                        n_count = r_count - AW'(1);
                        wr_addr = r_count - AW'(1);
                        if (rx_byte == CH_DEL) begin
                            n_val[1]   = CH_BS;
                            n_val[2]   = CH_SP;
                            n_val[3]   = CH_BS;
                            n_last_idx = RES_IDX_W'(3);
                        end else begin
                            n_val[1]   = CH_SP;
                            n_val[2]   = CH_BS;
                            n_last_idx = RES_IDX_W'(2);
                        end
                    end
                end
            end
            OP_SET_FACTORY: begin
                n_factory = 1'b1;
                n_kind[0] = KIND_STATUS;
            end
            OP_CLEAR_LINE: begin
                n_count   = '0;
                n_fill    = '0;
                n_done    = 1'b0;
                n_kind[0] = KIND_STATUS;
            end
            OP_READ_ENTRY: begin
                n_kind[0] = KIND_READ;
                n_is_read = 1'b1;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture  <= 1'b0;
            r_line_end <= LINE_END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPTURE_MODE:  r_capture  <= i_cfg_data[0];
                CFG_LINE_END_CHAR: r_line_end <= i_cfg_data;
            endcase
        end
    end

    // Editor state, updated when an item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_fill    <= '0;
            r_done    <= 1'b0;
            r_factory <= 1'b0;
        end else if (in_acc) begin
            r_count   <= n_count;
            r_fill    <= n_fill;
            r_done    <= n_done;
            r_factory <= n_factory;
        end
    end

    // Line store; a write and a read never come from the same item
    always_ff @(posedge i_clk) begin
        if (in_acc && wr_en) begin
            r_line_mem[wr_addr] <= wr_data;
        end
        if (in_acc && n_is_read) begin
            r_rd_data <= r_line_mem[AW'(i_in_item.entry_index)];
        end
    end

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (in_acc) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (out_acc) begin
            if (out_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last_idx <= n_last_idx;
            r_is_read  <= n_is_read;
            r_in_range <= LW'(i_in_item.entry_index) < LW'(r_fill);
            for (int k = 0; k < RES_MAX; k++) begin
                r_kind[k] <= n_kind[k];
                r_val[k]  <= n_val[k];
            end
        end
    end

    // Drive the current result
    always_comb begin
        o_out_valid            = r_valid;
        o_out_item.kind        = r_kind[r_idx];
        o_out_item.value       = r_val[r_idx];
        if (r_is_read) begin
            o_out_item.value = r_in_range ? r_rd_data : 8'h00;
        end
        o_out_item.line_length = 8'(r_count);
        o_out_item.line_done   = r_done;
        o_out_item.factory_on  = r_factory;
        o_out_item.last        = out_last;
    end

    // Checks
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_last_idx))
        else $error("result index past last result");

    a_count_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} <= r_fill) && (r_fill <= (AW+1)'(LINE_LEN)))
        else $error("line count outside fill mark");

    a_take_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_valid || (out_acc && out_last)))
        else $error("item taken while results still pending");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.operation == OP_CLEAR_LINE)
        |=> (r_count == '0 && r_fill == '0 && !r_done))
        else $error("clear line left state behind");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !out_last && !in_acc)
        |=> (r_valid && r_idx == $past(r_idx) + RES_IDX_W'(1)))
        else $error("result sequence did not advance");

endmodule
